FILE: sv/udiv_pkg.sv
// Shared types and constants for the unsigned 64-bit divider.
// No dependencies; used by every module of the divider.
`timescale 1ns / 1ps
`default_nettype none
package udiv_pkg;

  localparam int DW          = 64;   // datapath width of the division
  localparam int FIELD_W     = 64;   // width of each field on the ports
  localparam int IN_TDATA_W  = 128;  // dividend, divisor
  localparam int OUT_TDATA_W = 128;  // quotient, remainder
  localparam int OUT_TUSER_W = 1;    // divide_by_zero
  localparam int NUM_CELLS   = DW;   // one quotient bit per cell

  // State handed from one cell to the next.
  // nq: dividend bits still to enter at the top, quotient bits collected at the bottom.
  typedef struct packed {
    logic          valid;
    logic [DW-1:0] part;
    logic [DW-1:0] nq;
    logic [DW-1:0] den;
  } udiv_stage_t;

  typedef struct packed {
    logic [DW-1:0] quo;
    logic [DW-1:0] rem;
    logic          dz;
  } udiv_result_t;

endpackage
`default_nettype wire

FILE: sv/udiv_cell.sv
// One restoring division step: shift in a dividend bit, trial subtract, keep or restore.
// Depends on udiv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module udiv_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   en,
  input  udiv_pkg::udiv_stage_t prev,
  output udiv_pkg::udiv_stage_t stage
);
  import udiv_pkg::*;

  logic [DW:0] shifted;
  logic [DW:0] diff;
  logic        take;

  // partial remainder is DW+1 bits after the shift; no borrow means subtract
  assign shifted = {prev.part, prev.nq[DW-1]};
  assign diff    = shifted - {1'b0, prev.den};
  assign take    = ~diff[DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= prev.valid;
    end
    if (en) begin
      stage.part <= take ? diff[DW-1:0] : shifted[DW-1:0];
      stage.nq   <= {prev.nq[DW-2:0], take};
      stage.den  <= prev.den;
    end
  end

endmodule
`default_nettype wire

FILE: sv/udiv_outbuf.sv
// Two-entry output buffer that decouples the cell chain from the result consumer.
// Depends on udiv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module udiv_outbuf (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  input  udiv_pkg::udiv_result_t in_res,
  output logic                   advance,
  output logic                   out_valid,
  input  wire                    out_ready,
  output udiv_pkg::udiv_result_t out_res
);
  import udiv_pkg::*;

  udiv_result_t entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic [1:0]   count_next;
  logic         push;
  logic         pop;

  // chain moves only when a slot is guaranteed; purely registered decision
  assign advance   = (count != 2'd2);
  assign push      = advance & in_valid;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid & out_ready;
  assign out_res   = entries[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_res;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer count out of range");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) && !out_ready |=> (count == 2'd2))
    else $error("full buffer lost an entry without a pop");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> (wr_ptr == rd_ptr))
    else $error("empty buffer with mismatched pointers");

endmodule
`default_nettype wire

FILE: sv/unsigned_divider_64_top.sv
// Top level of the pipelined unsigned 64-bit restoring divider.
// Depends on udiv_pkg, udiv_cell and udiv_outbuf.
`timescale 1ns / 1ps
`default_nettype none
// Takes one dividend/divisor beat per cycle while s_tready is high and returns
// quotient and remainder through a chain of 64 cells, each forming one quotient
// bit, then a two-entry output buffer. Throughput is one division per cycle
// while the chain advances one cell per clock. When the output buffer holds two
// unclaimed beats the whole chain holds and s_tready drops. A zero divisor
// returns an all-ones quotient, zero remainder and divide_by_zero on m_tuser.
module unsigned_divider_64_top (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [udiv_pkg::IN_TDATA_W-1:0]     s_tdata,   // dividend[63:0], divisor[127:64]
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [udiv_pkg::OUT_TDATA_W-1:0]    m_tdata,   // quotient[63:0], remainder[127:64]
  output logic [udiv_pkg::OUT_TUSER_W-1:0]    m_tuser    // divide_by_zero[0]
);
  import udiv_pkg::*;

  udiv_stage_t  chain [NUM_CELLS+1];
  udiv_result_t last_res;
  udiv_result_t out_res;
  logic         advance;
  logic         last_dz;

  assign s_tready = advance;

  assign chain[0].valid = s_tvalid & advance;
  assign chain[0].part  = '0;
  assign chain[0].nq    = s_tdata[DW-1:0];
  assign chain[0].den   = s_tdata[FIELD_W+DW-1:FIELD_W];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    udiv_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (advance),
      .prev  (chain[i]),
      .stage (chain[i+1])
    );
  end

  // zero divisor: force the defined result
  assign last_dz      = (chain[NUM_CELLS].den == '0);
  assign last_res.quo = last_dz ? {DW{1'b1}} : chain[NUM_CELLS].nq;
  assign last_res.rem = last_dz ? {DW{1'b0}} : chain[NUM_CELLS].part;
  assign last_res.dz  = last_dz;

  udiv_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain[NUM_CELLS].valid),
    .in_res    (last_res),
    .advance   (advance),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  always_comb begin
    m_tdata                          = '0;
    m_tdata[DW-1:0]                  = out_res.quo;
    m_tdata[FIELD_W+DW-1:FIELD_W]    = out_res.rem;
    m_tuser                          = '0;
    m_tuser[0]                       = out_res.dz;
  end

  a_dz_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      (out_res.quo == {DW{1'b1}}) && (out_res.rem == {DW{1'b0}}))
    else $error("divide-by-zero beat with wrong quotient or remainder");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    chain[NUM_CELLS].valid && !last_dz |->
      (chain[NUM_CELLS].part < chain[NUM_CELLS].den))
    else $error("remainder not below divisor at end of chain");

endmodule
`default_nettype wire

FILE: verif/unsigned_divider_64_top_tb.sv
// Self-checking testbench for unsigned_divider_64_top: directed and random divisions, each
// checked against a table result or a restoring-division predictor. Depends on udiv_pkg.
`timescale 1ns / 1ps
module unsigned_divider_64_top_tb;
  import udiv_pkg::*;

  localparam int  N_RANDOM    = 1734;     // split over three idle phases
  localparam int  HOLD_CYCLES = 300;      // long m_tready hold-off to back up the chain
  localparam int  DRAIN_CYCLES = 20000;
  localparam int  TAIL_CYCLES = 70;       // idle margin beyond pipeline depth plus output buffer
  localparam time RUN_LIMIT   = 2ms;

  typedef logic [DW-1:0] word_t;

  typedef struct {
    word_t        num;
    word_t        den;
    bit           typed;     // expected result written in the table
    udiv_result_t res;
  } div_case_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // dividend[63:0], divisor[127:64]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // quotient[63:0], remainder[127:64]
  logic [OUT_TUSER_W-1:0] m_tuser;   // divide_by_zero[0]

  div_case_t    dir_cases[$];
  udiv_result_t pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;
  int n_errors;
  int n_sent;
  int n_zero_div;
  int n_results;
  int n_input_stalls;

  unsigned_divider_64_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("timeout: %0d divisions still pending", pending_results.size());
    $display("** unsigned_divider_64_top: FAILED **");
    $finish;
  end

  // Shift-subtract with a partial remainder one bit wider than the operands,
  // so divisors with the top bit set come out right.
  function automatic udiv_result_t divide_restoring(word_t num, word_t den);
    udiv_result_t r;
    logic [DW:0]  acc;
    r.quo = '0;
    r.rem = '0;
    r.dz  = 1'b0;
    if (den == '0) begin
      r.quo = '1;
      r.dz  = 1'b1;
      return r;
    end
    acc = '0;
    for (int i = DW - 1; i >= 0; i--) begin
      acc = {acc[DW-1:0], num[i]};
      if (acc >= {1'b0, den}) begin
        acc      = acc - {1'b0, den};
        r.quo[i] = 1'b1;
      end
    end
    r.rem = acc[DW-1:0];
    return r;
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Operand mix: wide and narrow divisors, top-bit divisors, divisor multiples plus
  // a remainder, dividend below divisor, powers of two and the odd zero divisor.
  task automatic make_operands(output word_t a, output word_t b);
    int    pick;
    word_t q;
    pick = $urandom_range(99);
    a = rand_word();
    b = rand_word();
    if (pick < 4) begin
      b = '0;
    end else if (pick < 30) begin
      a = a >> $urandom_range(8);
    end else if (pick < 60) begin
      b = b >> $urandom_range(63, 1);
      a = a >> $urandom_range(20);
    end else if (pick < 75) begin
      b[DW-1] = 1'b1;
    end else if (pick < 85) begin
      b = b >> $urandom_range(63, 32);
      if (b == '0) b = word_t'(1);
      q = rand_word() >> $urandom_range(63, 32);
      a = b * q + (rand_word() % b);
    end else if (pick < 92) begin
      if (b == '0) b = word_t'(1);
      a = a % b;
    end else begin
      b = word_t'(1) << $urandom_range(DW - 1);
    end
  endtask

  task automatic add_case(word_t num, word_t den, bit typed,
                          word_t quo = '0, word_t rem = '0, bit dz = 1'b0);
    div_case_t c;
    c.num     = num;
    c.den     = den;
    c.typed   = typed;
    c.res.quo = quo;
    c.res.rem = rem;
    c.res.dz  = dz;
    dir_cases.push_back(c);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_division(word_t num, word_t den, bit typed, udiv_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {den, num};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(typed ? res : divide_restoring(num, den));
    n_sent++;
    if (den == '0) n_zero_div++;
    @(negedge clk);
  endtask

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Receiver: random m_tready, with a counted hold-off on request.
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && !s_tready) n_input_stalls++;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", m_tdata[FIELD_W-1:0], '0);
      end else begin
        udiv_result_t want;
        want = pending_results.pop_front();
        if (m_tdata[FIELD_W-1:0] !== want.quo)
          report_mismatch("quotient", m_tdata[FIELD_W-1:0], want.quo);
        if (m_tdata[2*FIELD_W-1:FIELD_W] !== want.rem)
          report_mismatch("remainder", m_tdata[2*FIELD_W-1:FIELD_W], want.rem);
        if (m_tuser[0] !== want.dz)
          report_mismatch("divide_by_zero", word_t'(m_tuser[0]), word_t'(want.dz));
      end
    end
  end

  initial begin
    word_t        a;
    word_t        b;
    udiv_result_t none;
    int           waited;

    none           = '0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    hold_req       = 1'b0;
    send_idle_pct  = 29;
    recv_idle_pct  = 48;
    n_errors       = 0;
    n_sent         = 0;
    n_zero_div     = 0;
    n_results      = 0;
    n_input_stalls = 0;

    // zero divisor
    add_case('0, '0, 1'b1, '1, '0, 1'b1);
    add_case('1, '0, 1'b1, '1, '0, 1'b1);
    add_case(64'h0123_4567_89ab_cdef, '0, 1'b1, '1, '0, 1'b1);
    // operand extremes
    add_case('0, 64'd1, 1'b1, '0, '0);
    add_case('1, 64'd1, 1'b1, '1, '0);
    add_case('1, '1, 1'b1, 64'd1, '0);
    add_case('0, '1, 1'b1, '0, '0);
    add_case(64'd1, '1, 1'b1, '0, 64'd1);
    add_case(64'hffff_ffff_ffff_fffe, '1, 1'b1, '0, 64'hffff_ffff_ffff_fffe);
    add_case('1, 64'd2, 1'b1, 64'h7fff_ffff_ffff_ffff, 64'd1);
    // divisor with the top bit set: partial remainder overflows 64 bits
    add_case(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1, 64'd1, '0);
    add_case('1, 64'h8000_0000_0000_0000, 1'b1, 64'd1, 64'h7fff_ffff_ffff_ffff);
    add_case('1, 64'h8000_0000_0000_0001, 1'b0);
    add_case(64'h8000_0000_0000_0005, 64'h8000_0000_0000_0001, 1'b0);
    add_case(64'hc000_0000_0000_0000, 64'hbfff_ffff_ffff_ffff, 1'b0);
    // ordinary cases
    add_case(64'd100, 64'd7, 1'b0);
    add_case(64'hdead_beef_cafe_f00d, 64'h1_0000_0001, 1'b0);
    add_case('1, 64'hffff_ffff, 1'b0);
    add_case(64'h4000_0000_0000_0000, 64'd3, 1'b0);
    add_case(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaab, 1'b0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_cases[i])
      send_division(dir_cases[i].num, dir_cases[i].den, dir_cases[i].typed,
                    dir_cases[i].res);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 29 : 0;
      if (phase == 2) hold_req = 1'b1;  // back the pipe up with the sender going flat out
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        make_operands(a, b);
        send_division(a, b, 1'b0, none);
      end
    end
    s_tvalid = 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0d divisions never returned a result", pending_results.size());
      n_errors++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("divisions sent %0d (%0d by zero), results checked %0d, mismatches %0d",
             n_sent, n_zero_div, n_results, n_errors);
    $display("input backpressure cycles seen: %0d", n_input_stalls);
    if (n_errors == 0) begin
      $display("** unsigned_divider_64_top: PASSED **");
    end else begin
      $display("** unsigned_divider_64_top: FAILED **");
    end
    $finish;
  end

endmodule
